// ----- design/assert_macros.svh -----
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, disabled while reset is held
`define TCC_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error(msg);

// clocked assertion that also holds across reset
`define TCC_ASSERT_RST(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// ----- design/tcc_pkg.sv -----
`default_nettype none

package tcc_pkg;

    localparam int MAX_DIMS    = 4;
    localparam int EXTENT_BITS = 8;
    localparam int SLOTS       = 4;
    localparam int SLOT_W      = 2;
    localparam int DIGIT_W     = 8;
    localparam int EXT_W       = 9;
    localparam int INDEX_W     = 32;
    localparam int COUNT_W     = 33;
    localparam int VALUE_W     = 48;
    localparam int DCNT_W      = 3;
    localparam int CFG_IDX_W   = 3;
    localparam int STEP_W      = 6;

    localparam int S_TDATA_W   = VALUE_W + SLOTS * DIGIT_W;
    localparam int S_TUSER_W   = 2;
    localparam int M_TDATA_W   = SLOTS * DIGIT_W + INDEX_W;
    localparam int M_TUSER_W   = 1;

    localparam logic [EXT_W-1:0]  EXT_MAX  = EXT_W'(1 << EXTENT_BITS);
    localparam logic [DCNT_W-1:0] DIMS_TOP = DCNT_W'((MAX_DIMS < SLOTS) ? MAX_DIMS : SLOTS);

    typedef enum logic [1:0] {
        OP_INC       = 2'd0,
        OP_DEC       = 2'd1,
        OP_SET_INDEX = 2'd2,
        OP_SET_COORD = 2'd3
    } t_op;

    localparam logic [CFG_IDX_W-1:0] REG_DIM_COUNT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_EXTENT0   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_EXTENT1   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_EXTENT2   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_EXTENT3   = 3'd4;

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_EXEC = 7'b0000010,
        S_PROD = 7'b0000100,
        S_MAC  = 7'b0001000,
        S_DIV  = 7'b0010000,
        S_FIX  = 7'b0100000,
        S_DONE = 7'b1000000
    } t_state;

    function automatic logic [EXT_W-1:0] eff_extent(input logic [EXT_W-1:0] raw);
        logic [EXT_W-1:0] e;
        e = raw;
        if (raw == '0) e = EXT_W'(1);
        if (raw > EXT_MAX) e = EXT_MAX;
        return e;
    endfunction

    function automatic logic [DCNT_W-1:0] dims_in_use(input logic [DCNT_W-1:0] dc);
        return (dc > DIMS_TOP) ? DIMS_TOP : dc;
    endfunction

endpackage

`default_nettype wire

// ----- design/tensor_coordinate_counter.sv -----
`default_nettype none

// Tensor coordinate counter: keeps a coordinate of up to four digits (dimension 0
// outermost) and its row-major linear index for a configured shape.
// Input stream: tuser carries the operation (increment, decrement, set from
// linear index, set from coordinates), tdata the index and the four digits.
// Output stream: one transaction per input transaction with the digits, the
// linear position and, in tuser, the bad coordinate flag.
// Config channel: index 0 dimension count, 1..4 extents; a write to one of these
// clears the coordinate and rebuilds the element count, one multiply per dimension.
// Increment, decrement, rejected set-from-coordinates and zero dimensions finish
// directly; set-from-coordinates goes through the shared multiply-add;
// set-from-index runs on the shared one-bit-per-cycle divider (48 steps for
// the reduction, 32 per digit).
// One transaction is processed at a time; s_axis_tready is high only when idle.
// A finished result sits in the output register; if the receiver stalls, the
// next result waits inside until that register frees up.
// Reset: one dimension of extent 1, coordinate zero, no output pending.

module tensor_coordinate_counter
    import tcc_pkg::*;
(
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   s_axis_tvalid,
    output logic                  s_axis_tready,
    // index_value[47:0], coord_in0, coord_in1, coord_in2, coord_in3
    input  wire  [S_TDATA_W-1:0]  s_axis_tdata,
    // operation[1:0]
    input  wire  [S_TUSER_W-1:0]  s_axis_tuser,
    output logic                  m_axis_tvalid,
    input  wire                   m_axis_tready,
    // coord_out0, coord_out1, coord_out2, coord_out3, linear_position[31:0]
    output logic [M_TDATA_W-1:0]  m_axis_tdata,
    // bad_coordinate
    output logic [M_TUSER_W-1:0]  m_axis_tuser,
    input  wire                   i_cfg_valid,
    output logic                  o_cfg_ready,
    input  wire  [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire  [EXT_W-1:0]      i_cfg_data
);

    localparam int MUL_W = COUNT_W + EXT_W;
    localparam int PAD_W = VALUE_W - INDEX_W;
    localparam logic [STEP_W-1:0] STEPS_FULL  = STEP_W'(VALUE_W);
    localparam logic [STEP_W-1:0] STEPS_SPLIT = STEP_W'(INDEX_W);

    t_state                r_state, n_state;
    t_op                   r_op, n_op;
    logic [DCNT_W-1:0]     r_dim_count, n_dim_count;
    logic [EXT_W-1:0]      r_extent [SLOTS];
    logic [EXT_W-1:0]      n_extent [SLOTS];
    logic [DIGIT_W-1:0]    r_digit [SLOTS];
    logic [DIGIT_W-1:0]    n_digit [SLOTS];
    logic [DIGIT_W-1:0]    r_cin [SLOTS];
    logic [DIGIT_W-1:0]    n_cin [SLOTS];
    logic [INDEX_W-1:0]    r_index, n_index;
    logic [COUNT_W-1:0]    r_count, n_count;
    logic [VALUE_W-1:0]    r_value, n_value;
    logic [COUNT_W-1:0]    r_acc, n_acc;
    logic [DCNT_W-1:0]     r_cnt, n_cnt;
    logic                  r_neg, n_neg;
    logic                  r_phase, n_phase;
    logic                  r_bad, n_bad;
    logic [VALUE_W-1:0]    r_div_q, n_div_q;
    logic [COUNT_W-1:0]    r_div_r, n_div_r;
    logic [COUNT_W-1:0]    r_div_d, n_div_d;
    logic [STEP_W-1:0]     r_steps, n_steps;
    logic                  r_out_valid, n_out_valid;
    logic [DIGIT_W-1:0]    r_out_dig [SLOTS];
    logic [DIGIT_W-1:0]    n_out_dig [SLOTS];
    logic [INDEX_W-1:0]    r_out_pos, n_out_pos;
    logic                  r_out_bad, n_out_bad;

    logic [DCNT_W-1:0]     w_dims;
    logic [EXT_W-1:0]      w_ext [SLOTS];
    logic [DIGIT_W-1:0]    w_inc_dig [SLOTS];
    logic [DIGIT_W-1:0]    w_dec_dig [SLOTS];
    logic [INDEX_W-1:0]    w_inc_idx, w_dec_idx;
    logic [COUNT_W-1:0]    w_idx_p1;
    logic                  w_coord_bad;
    logic [SLOT_W-1:0]     w_sel;
    logic [MUL_W-1:0]      w_mul;
    logic [DIGIT_W-1:0]    w_mul_add;
    logic [COUNT_W:0]      w_rem_sh;
    logic                  w_ge;
    logic [COUNT_W:0]      w_rem_diff;
    logic [COUNT_W-1:0]    w_rem_nx;
    logic [VALUE_W-1:0]    w_q_nx;
    logic [COUNT_W-1:0]    w_fixed;
    logic [DCNT_W-1:0]     w_dims_m1;
    logic [DCNT_W-1:0]     w_cnt_m1;
    logic                  w_out_free;
    logic                  w_finish;
    logic                  w_cfg_write;
    logic                  v_carry, v_borrow;
    logic [EXT_W-1:0]      v_sum;

    assign w_dims = dims_in_use(r_dim_count);

    always_comb begin
        for (int i = 0; i < SLOTS; i++) begin
            w_ext[i] = eff_extent(r_extent[i]);
        end
    end

    // odometer step, innermost digit first
    always_comb begin
        v_carry  = 1'b1;
        v_borrow = 1'b1;
        v_sum    = '0;
        for (int i = SLOTS - 1; i >= 0; i--) begin
            w_inc_dig[i] = r_digit[i];
            w_dec_dig[i] = r_digit[i];
            if (DCNT_W'(i) < w_dims) begin
                if (v_carry) begin
                    v_sum = {1'b0, r_digit[i]} + EXT_W'(1);
                    if (v_sum < w_ext[i]) begin
                        w_inc_dig[i] = v_sum[DIGIT_W-1:0];
                        v_carry = 1'b0;
                    end else begin
                        w_inc_dig[i] = '0;
                    end
                end
                if (v_borrow) begin
                    if (r_digit[i] != '0) begin
                        w_dec_dig[i] = r_digit[i] - DIGIT_W'(1);
                        v_borrow = 1'b0;
                    end else begin
                        w_dec_dig[i] = DIGIT_W'(w_ext[i] - EXT_W'(1));
                    end
                end
            end
        end
    end

    assign w_idx_p1  = {1'b0, r_index} + COUNT_W'(1);
    assign w_inc_idx = (w_idx_p1 >= r_count) ? '0 : w_idx_p1[INDEX_W-1:0];
    assign w_dec_idx = (r_index == '0) ? INDEX_W'(r_count - COUNT_W'(1))
                                       : (r_index - INDEX_W'(1));

    always_comb begin
        w_coord_bad = 1'b0;
        for (int i = 0; i < SLOTS; i++) begin
            if ((DCNT_W'(i) < w_dims) && ({1'b0, r_cin[i]} >= w_ext[i])) begin
                w_coord_bad = 1'b1;
            end
        end
    end

    // shared multiply-add
    assign w_sel     = r_cnt[SLOT_W-1:0];
    assign w_mul_add = (r_state == S_MAC) ? r_digit[w_sel] : '0;
    assign w_mul     = MUL_W'(r_acc) * MUL_W'(w_ext[w_sel]) + MUL_W'(w_mul_add);

    // shared restoring divider, one quotient bit per cycle
    assign w_rem_sh   = {r_div_r, r_div_q[VALUE_W-1]};
    assign w_rem_diff = w_rem_sh - {1'b0, r_div_d};
    assign w_ge       = (w_rem_sh >= {1'b0, r_div_d});
    assign w_rem_nx   = w_ge ? w_rem_diff[COUNT_W-1:0] : w_rem_sh[COUNT_W-1:0];
    assign w_q_nx     = {r_div_q[VALUE_W-2:0], w_ge};

    assign w_fixed   = (r_neg && (r_div_r != '0)) ? (r_count - r_div_r) : r_div_r;
    assign w_dims_m1 = w_dims - DCNT_W'(1);
    assign w_cnt_m1  = r_cnt - DCNT_W'(1);

    assign w_out_free    = !r_out_valid || m_axis_tready;
    assign s_axis_tready = (r_state == S_IDLE) && !i_cfg_valid;
    assign o_cfg_ready   = (r_state == S_IDLE);

    always_comb begin
        n_state     = r_state;
        n_op        = r_op;
        n_dim_count = r_dim_count;
        n_extent    = r_extent;
        n_digit     = r_digit;
        n_cin       = r_cin;
        n_index     = r_index;
        n_count     = r_count;
        n_value     = r_value;
        n_acc       = r_acc;
        n_cnt       = r_cnt;
        n_neg       = r_neg;
        n_phase     = r_phase;
        n_bad       = r_bad;
        n_div_q     = r_div_q;
        n_div_r     = r_div_r;
        n_div_d     = r_div_d;
        n_steps     = r_steps;
        n_out_valid = r_out_valid && !m_axis_tready;
        n_out_dig   = r_out_dig;
        n_out_pos   = r_out_pos;
        n_out_bad   = r_out_bad;
        w_finish    = 1'b0;
        w_cfg_write = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (i_cfg_valid) begin
                    w_cfg_write = 1'b1;
                    case (i_cfg_index)
                        REG_DIM_COUNT: n_dim_count = i_cfg_data[DCNT_W-1:0];
                        REG_EXTENT0:   n_extent[0] = i_cfg_data;
                        REG_EXTENT1:   n_extent[1] = i_cfg_data;
                        REG_EXTENT2:   n_extent[2] = i_cfg_data;
                        REG_EXTENT3:   n_extent[3] = i_cfg_data;
                        default:       w_cfg_write = 1'b0;
                    endcase
                    if (w_cfg_write) begin
                        for (int i = 0; i < SLOTS; i++) begin
                            n_digit[i] = '0;
                        end
                        n_index = '0;
                        n_acc   = COUNT_W'(1);
                        n_cnt   = '0;
                        n_state = S_PROD;
                    end
                end else if (s_axis_tvalid) begin
                    n_op    = t_op'(s_axis_tuser[1:0]);
                    n_value = s_axis_tdata[VALUE_W-1:0];
                    for (int i = 0; i < SLOTS; i++) begin
                        n_cin[i] = s_axis_tdata[VALUE_W + i*DIGIT_W +: DIGIT_W];
                    end
                    n_state = S_EXEC;
                end
            end
            S_PROD: begin
                if (r_cnt < w_dims) begin
                    n_acc = w_mul[COUNT_W-1:0];
                    n_cnt = r_cnt + DCNT_W'(1);
                end else begin
                    n_count = r_acc;
                    n_state = S_IDLE;
                end
            end
            S_EXEC: begin
                n_bad = 1'b0;
                if (w_dims == '0) begin
                    w_finish = 1'b1;
                end else begin
                    case (r_op)
                        OP_INC: begin
                            n_digit  = w_inc_dig;
                            n_index  = w_inc_idx;
                            w_finish = 1'b1;
                        end
                        OP_DEC: begin
                            n_digit  = w_dec_dig;
                            n_index  = w_dec_idx;
                            w_finish = 1'b1;
                        end
                        OP_SET_INDEX: begin
                            n_neg   = r_value[VALUE_W-1];
                            n_div_q = r_value[VALUE_W-1] ? (VALUE_W'(0) - r_value) : r_value;
                            n_div_r = '0;
                            n_div_d = r_count;
                            n_steps = STEPS_FULL;
                            n_phase = 1'b0;
                            n_state = S_DIV;
                        end
                        OP_SET_COORD: begin
                            if (w_coord_bad) begin
                                n_bad    = 1'b1;
                                w_finish = 1'b1;
                            end else begin
                                for (int i = 0; i < SLOTS; i++) begin
                                    if (DCNT_W'(i) < w_dims) n_digit[i] = r_cin[i];
                                end
                                n_acc   = '0;
                                n_cnt   = '0;
                                n_state = S_MAC;
                            end
                        end
                        default: w_finish = 1'b1;
                    endcase
                end
            end
            S_MAC: begin
                if (r_cnt < w_dims) begin
                    n_acc = w_mul[COUNT_W-1:0];
                    n_cnt = r_cnt + DCNT_W'(1);
                end else begin
                    n_index  = r_acc[INDEX_W-1:0];
                    w_finish = 1'b1;
                end
            end
            S_DIV: begin
                n_div_q = w_q_nx;
                n_div_r = w_rem_nx;
                n_steps = r_steps - STEP_W'(1);
                if (r_steps == STEP_W'(1)) begin
                    if (!r_phase) begin
                        n_state = S_FIX;
                    end else begin
                        n_digit[w_sel] = w_rem_nx[DIGIT_W-1:0];
                        if (r_cnt == '0) begin
                            w_finish = 1'b1;
                        end else begin
                            n_cnt   = w_cnt_m1;
                            n_div_q = {w_q_nx[INDEX_W-1:0], PAD_W'(0)};
                            n_div_r = '0;
                            n_div_d = COUNT_W'(w_ext[w_cnt_m1[SLOT_W-1:0]]);
                            n_steps = STEPS_SPLIT;
                        end
                    end
                end
            end
            S_FIX: begin
                n_index = w_fixed[INDEX_W-1:0];
                n_div_q = {w_fixed[INDEX_W-1:0], PAD_W'(0)};
                n_div_r = '0;
                n_div_d = COUNT_W'(w_ext[w_dims_m1[SLOT_W-1:0]]);
                n_cnt   = w_dims_m1;
                n_steps = STEPS_SPLIT;
                n_phase = 1'b1;
                n_state = S_DIV;
            end
            S_DONE: begin
                w_finish = 1'b1;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (w_finish) begin
            if (w_out_free) begin
                n_out_valid = 1'b1;
                n_out_dig   = n_digit;
                n_out_pos   = n_index;
                n_out_bad   = n_bad;
                n_state     = S_IDLE;
            end else begin
                n_state = S_DONE;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_dim_count <= DCNT_W'(1);
            for (int i = 0; i < SLOTS; i++) begin
                r_extent[i] <= EXT_W'(1);
                r_digit[i]  <= '0;
            end
            r_index     <= '0;
            r_count     <= COUNT_W'(1);
            r_bad       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_dim_count <= n_dim_count;
            r_extent    <= n_extent;
            r_digit     <= n_digit;
            r_index     <= n_index;
            r_count     <= n_count;
            r_bad       <= n_bad;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op      <= n_op;
        r_cin     <= n_cin;
        r_value   <= n_value;
        r_acc     <= n_acc;
        r_cnt     <= n_cnt;
        r_neg     <= n_neg;
        r_phase   <= n_phase;
        r_div_q   <= n_div_q;
        r_div_r   <= n_div_r;
        r_div_d   <= n_div_d;
        r_steps   <= n_steps;
        r_out_dig <= n_out_dig;
        r_out_pos <= n_out_pos;
        r_out_bad <= n_out_bad;
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {r_out_pos, r_out_dig[3], r_out_dig[2], r_out_dig[1], r_out_dig[0]};
    assign m_axis_tuser  = r_out_bad;

endmodule

`default_nettype wire

// ----- design/tcc_checker.sv -----
`default_nettype none

`include "assert_macros.svh"

module tcc_checker
    import tcc_pkg::*;
(
    input wire                  i_clk,
    input wire                  i_rst_n,
    input wire                  s_axis_tvalid,
    input wire                  s_axis_tready,
    input wire [S_TDATA_W-1:0]  s_axis_tdata,
    input wire [S_TUSER_W-1:0]  s_axis_tuser,
    input wire                  m_axis_tvalid,
    input wire                  m_axis_tready,
    input wire [M_TDATA_W-1:0]  m_axis_tdata,
    input wire [M_TUSER_W-1:0]  m_axis_tuser,
    input wire                  i_cfg_valid,
    input wire                  o_cfg_ready,
    input wire [CFG_IDX_W-1:0]  i_cfg_index,
    input wire [EXT_W-1:0]      i_cfg_data
);

    // stalled result holds
    `TCC_ASSERT(a_out_hold, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "result changed under stall")

    // one transaction at a time
    `TCC_ASSERT(a_busy_after_accept, s_axis_tvalid && s_axis_tready |=> !s_axis_tready && !o_cfg_ready, "input taken while busy")

    // register write starts the element count rebuild
    `TCC_ASSERT(a_busy_after_cfg, i_cfg_valid && o_cfg_ready && i_cfg_index <= REG_EXTENT3 |=> !s_axis_tready && !o_cfg_ready, "no rebuild after register write")

    // reset leaves no result pending and the block idle
    `TCC_ASSERT_RST(a_reset_idle, !i_rst_n |=> !m_axis_tvalid && o_cfg_ready, "state after reset")

endmodule

bind tensor_coordinate_counter tcc_checker u_tcc_checker (.*);

`default_nettype wire
